FILE: sv/wind_vane_heading_calibrator_top_macros.svh
// Assertion macros shared by the calibrator RTL.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef WIND_VANE_HEADING_CALIBRATOR_TOP_MACROS_SVH
`define WIND_VANE_HEADING_CALIBRATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define WVHC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wvhc assertion failed");

// next-cycle implication, checked outside reset
`define WVHC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wvhc assertion failed");

`endif

FILE: sv/wvhc_pkg.sv
// Shared constants, widths and the controller command type of the calibrator.
// No dependencies.
package wvhc_pkg;

	localparam int SAMPLE_COUNT = 16;
	localparam int FAULT_LIMIT  = 10;

	localparam int ANGLE_W = 10;
	localparam int DEG_W   = 9;
	localparam int FAULT_W = 8;
	localparam int CNT_W   = $clog2(SAMPLE_COUNT + 1);
	localparam int PROD_W  = ANGLE_W + DEG_W;

	localparam int DEG_TURN = 360;
	localparam int DEG_FLIP = 180;

	// middle window of the sorted samples
	localparam int MID_N  = ((SAMPLE_COUNT % 2) == 0) ? 4 : 3;
	localparam int MID_LO = ((SAMPLE_COUNT % 2) == 0) ? (SAMPLE_COUNT / 2 - 2)
		: (SAMPLE_COUNT / 2 - 1);
	localparam int SUM_W  = ANGLE_W + 2;

	// divide by four is a shift; divide by three is a reciprocal multiply
	localparam int MID_SH   = 2;
	localparam int DIV3_SH  = 14;
	localparam int DIV3_MUL = 5462;

	typedef struct packed {
		logic accept;
		logic calc;
		logic head;
		logic load;
	} wvhc_cmd_t;

endpackage

FILE: sv/wvhc_ctrl.sv
// Sequencer of the calibrator: accept, compute, finish, hand off the result.
// Depends on wvhc_pkg.
module wvhc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output wvhc_pkg::wvhc_cmd_t cmd
);
	import wvhc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_HEAD,
		S_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.calc   = (state_q == S_CALC);
		cmd.head   = (state_q == S_HEAD);
		cmd.load   = (state_q == S_LOAD) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.accept) state_q <= S_CALC;
				S_CALC: state_q <= S_HEAD;
				S_HEAD: state_q <= S_LOAD;
				S_LOAD: if (cmd.load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			// hold the result until taken
			if (cmd.load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/wvhc_dp.sv
// Datapath: fault tracking, sorted sample row, heading math and result register.
// Depends on wvhc_pkg; driven by wvhc_ctrl commands.
module wvhc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wvhc_pkg::wvhc_cmd_t           cmd,
	input  logic                          cfg_we,
	input  logic [wvhc_pkg::ANGLE_W-1:0]  cfg_wdata,
	input  logic                          action,
	input  logic [wvhc_pkg::ANGLE_W-1:0]  raw_angle,
	input  logic                          reading_valid,
	input  logic [wvhc_pkg::DEG_W-1:0]    compass_heading,
	output logic [wvhc_pkg::DEG_W-1:0]    heading,
	output logic                          heading_valid,
	output logic [wvhc_pkg::DEG_W-1:0]    absolute_heading,
	output logic                          sensor_online,
	output logic [wvhc_pkg::ANGLE_W-1:0]  zero_in_use,
	output logic                          calibration_done
);
	import wvhc_pkg::*;

	// captured request
	logic               action_q;
	logic [ANGLE_W-1:0] raw_q;
	logic               valid_q;
	logic [DEG_W-1:0]   compass_q;

	// persistent state
	logic [ANGLE_W-1:0] boot_zero_q;
	logic [ANGLE_W-1:0] cal_zero_q;
	logic               has_cal_q;
	logic [FAULT_W-1:0] fault_q;
	logic               online_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [ANGLE_W-1:0] row_q [SAMPLE_COUNT];

	// work registers
	logic [PROD_W-1:0]  prod_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic [DEG_W-1:0]   head_s2;

	logic [ANGLE_W-1:0] cur_zero;
	logic               hv;
	logic [SAMPLE_COUNT-1:0] le;
	logic [ANGLE_W-1:0] row_d [SAMPLE_COUNT];
	logic [ANGLE_W-1:0] diff;
	logic [SUM_W-1:0]   mid_sum;
	logic [SUM_W+DIV3_SH-1:0] div_prod;
	logic [ANGLE_W-1:0] mean;
	logic [DEG_W:0]     flip;
	logic [DEG_W-1:0]   head_d;
	logic [DEG_W:0]     abs_sum;
	logic [DEG_W-1:0]   abs_d;

	assign cur_zero = has_cal_q ? cal_zero_q : boot_zero_q;
	assign hv       = !action_q && valid_q;

	// insertion into the sorted row: filled cells not above the new value stay,
	// the rest shift up one place, the new value lands at the boundary
	always_comb begin
		for (int i = 0; i < SAMPLE_COUNT; i++) begin
			le[i] = (CNT_W'(i) < cnt_q) && (row_q[i] <= raw_angle);
		end
		for (int i = 0; i < SAMPLE_COUNT; i++) begin
			if (le[i]) row_d[i] = row_q[i];
			else if (i > 0 && !le[(i > 0) ? i - 1 : 0]) row_d[i] = row_q[(i > 0) ? i - 1 : 0];
			else row_d[i] = raw_angle;
		end
	end

	always_comb begin
		diff    = raw_q - cur_zero;
		mid_sum = '0;
		for (int k = 0; k < MID_N; k++) begin
			mid_sum = mid_sum + SUM_W'(row_q[MID_LO + k]);
		end
	end

	always_comb begin
		div_prod = (SUM_W + DIV3_SH)'(sum_s1) * (SUM_W + DIV3_SH)'(DIV3_MUL);
		if (MID_N == 4) mean = ANGLE_W'(sum_s1 >> MID_SH);
		else mean = ANGLE_W'(div_prod >> DIV3_SH);
	end

	always_comb begin
		flip = {1'b0, prod_s1[PROD_W-1:ANGLE_W]} + (DEG_W + 1)'(DEG_FLIP);
		if (flip >= (DEG_W + 1)'(DEG_TURN)) head_d = DEG_W'(flip - (DEG_W + 1)'(DEG_TURN));
		else head_d = DEG_W'(flip);
	end

	// heading plus compass stays below two turns plus a bit
	always_comb begin
		abs_sum = {1'b0, head_s2} + {1'b0, compass_q};
		if (abs_sum >= (DEG_W + 1)'(2 * DEG_TURN))
			abs_d = DEG_W'(abs_sum - (DEG_W + 1)'(2 * DEG_TURN));
		else if (abs_sum >= (DEG_W + 1)'(DEG_TURN))
			abs_d = DEG_W'(abs_sum - (DEG_W + 1)'(DEG_TURN));
		else abs_d = DEG_W'(abs_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_zero_q <= '0;
			cal_zero_q  <= '0;
			has_cal_q   <= 1'b0;
			fault_q     <= '0;
			online_q    <= 1'b1;
			cnt_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) boot_zero_q <= cfg_wdata;
			if (cmd.accept) begin
				if (!action) begin
					done_q <= 1'b0;
					if (fault_q > FAULT_W'(FAULT_LIMIT)) online_q <= 1'b0;
					if (!reading_valid) begin
						if (fault_q != '1) fault_q <= fault_q + 1'b1;
					end else begin
						fault_q <= '0;
					end
				end else if (cnt_q == CNT_W'(SAMPLE_COUNT - 1)) begin
					cnt_q  <= '0;
					done_q <= 1'b1;
				end else begin
					cnt_q  <= cnt_q + 1'b1;
					done_q <= 1'b0;
				end
			end
			if (cmd.head && done_q) begin
				cal_zero_q <= mean;
				has_cal_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q  <= action;
			raw_q     <= raw_angle;
			valid_q   <= reading_valid;
			compass_q <= compass_heading;
			if (action) begin
				for (int i = 0; i < SAMPLE_COUNT; i++) row_q[i] <= row_d[i];
			end
		end
		if (cmd.calc) begin
			prod_s1 <= PROD_W'(diff) * PROD_W'(DEG_TURN);
			sum_s1  <= mid_sum;
		end
		if (cmd.head) head_s2 <= hv ? head_d : '0;
		if (cmd.load) begin
			heading          <= head_s2;
			heading_valid    <= hv;
			absolute_heading <= hv ? abs_d : '0;
			sensor_online    <= online_q;
			zero_in_use      <= cur_zero;
			calibration_done <= done_q;
		end
	end

endmodule

FILE: sv/wind_vane_heading_calibrator_top.sv
// Top level of the wind vane heading calibrator: controller plus datapath.
// Depends on wvhc_pkg, wvhc_ctrl, wvhc_dp and the assertion macro header.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | action, raw_angle, reading_valid,
//          |                      | compass_heading
//  out     | out_valid/out_stall  | heading, heading_valid, absolute_heading,
//          |                      | sensor_online, zero_in_use, calibration_done
//  cfg     | cfg_we               | cfg_wdata (boot zero)
//
// Every request passes four steps in order: capture at the accepting edge,
// multiply or middle-sum, flip or mean, result load. The result is registered
// in the load step, and the next request can be taken in the cycle after the
// load, so a new request is not taken before the last one is through its load.
// Samples are kept sorted by insertion as they arrive; the middle window is read
// from fixed places. A stalled result holds in the output register, and the
// block waits in its load step only while that register is still full.
// Reset is asynchronous and needs no clearing pass.
`include "wind_vane_heading_calibrator_top_macros.svh"

module wind_vane_heading_calibrator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wvhc_pkg::ANGLE_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [wvhc_pkg::ANGLE_W-1:0]  raw_angle,
	input  logic                          reading_valid,
	input  logic [wvhc_pkg::DEG_W-1:0]    compass_heading,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wvhc_pkg::DEG_W-1:0]    heading,
	output logic                          heading_valid,
	output logic [wvhc_pkg::DEG_W-1:0]    absolute_heading,
	output logic                          sensor_online,
	output logic [wvhc_pkg::ANGLE_W-1:0]  zero_in_use,
	output logic                          calibration_done
);
	import wvhc_pkg::*;

	wvhc_cmd_t cmd;

	wvhc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	wvhc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.action           (action),
		.raw_angle        (raw_angle),
		.reading_valid    (reading_valid),
		.compass_heading  (compass_heading),
		.heading          (heading),
		.heading_valid    (heading_valid),
		.absolute_heading (absolute_heading),
		.sensor_online    (sensor_online),
		.zero_in_use      (zero_in_use),
		.calibration_done (calibration_done)
	);

	`WVHC_ASSERT_NEXT(a_busy_after_accept, cmd.accept, in_stall && !cmd.load)
	`WVHC_ASSERT_IMPL(a_invalid_zeroed, out_valid && !heading_valid, heading == '0 && absolute_heading == '0)
	`WVHC_ASSERT_IMPL(a_cal_no_heading, out_valid && calibration_done, !heading_valid)
	`WVHC_ASSERT_IMPL(a_deg_range, out_valid, heading < DEG_W'(DEG_TURN) && absolute_heading < DEG_W'(DEG_TURN))

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the wind vane heading calibrator top level.
// Depends on wvhc_pkg and wind_vane_heading_calibrator_top; predicts every
// result in place and compares it field by field with what the block returns.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_SAMP     = wvhc_pkg::SAMPLE_COUNT;
	localparam int FAULT_MAX  = wvhc_pkg::FAULT_LIMIT;
	localparam int ANG_W      = wvhc_pkg::ANGLE_W;
	localparam int HDG_W      = wvhc_pkg::DEG_W;
	localparam int RUN_SAT    = 255;
	localparam int WATCHDOG   = 5000;
	localparam int TAIL_WAIT  = 20;
	localparam int HOLD_LEN   = 300;
	localparam int HOLD_AT    = 60;
	localparam int MAX_PRINTS = 100;

	localparam logic ACT_READ   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic                          action;
		logic [wvhc_pkg::ANGLE_W-1:0]  raw;
		logic                          valid;
		logic [wvhc_pkg::DEG_W-1:0]    compass;
	} vane_req_t;

	typedef struct packed {
		logic [wvhc_pkg::DEG_W-1:0]    heading;
		logic                          hvalid;
		logic [wvhc_pkg::DEG_W-1:0]    abs_heading;
		logic                          online;
		logic [wvhc_pkg::ANGLE_W-1:0]  zero;
		logic                          done;
	} heading_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [wvhc_pkg::ANGLE_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	vane_req_t req_r = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [wvhc_pkg::DEG_W-1:0]   heading;
	logic                         heading_valid;
	logic [wvhc_pkg::DEG_W-1:0]   absolute_heading;
	logic                         sensor_online;
	logic [wvhc_pkg::ANGLE_W-1:0] zero_in_use;
	logic                         calibration_done;

	vane_req_t       pend_q[$];
	heading_result_t heading_q[$];

	int tx_idle_pct = 30;
	int rx_idle_pct = 83;
	int err_count = 0;
	int gen_run = 0;
	bit fault_ok = 1'b0;

	// shadow state of the calibrator
	logic [wvhc_pkg::ANGLE_W-1:0] sh_boot_zero = '0;
	logic [wvhc_pkg::ANGLE_W-1:0] sh_cal_zero = '0;
	logic                         sh_cal_valid = 1'b0;
	int                           sh_fault_run = 0;
	logic                         sh_online = 1'b1;
	logic [wvhc_pkg::ANGLE_W-1:0] sh_samples[N_SAMP];
	int                           sh_sample_cnt = 0;

	wind_vane_heading_calibrator_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (req_r.action),
		.raw_angle        (req_r.raw),
		.reading_valid    (req_r.valid),
		.compass_heading  (req_r.compass),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.heading          (heading),
		.heading_valid    (heading_valid),
		.absolute_heading (absolute_heading),
		.sensor_online    (sensor_online),
		.zero_in_use      (zero_in_use),
		.calibration_done (calibration_done)
	);

	always #5 clk = ~clk;

	task automatic note_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	function automatic logic [wvhc_pkg::ANGLE_W-1:0] middle_mean();
		logic [wvhc_pkg::ANGLE_W-1:0] srt[N_SAMP];
		logic [wvhc_pkg::ANGLE_W-1:0] key;
		int i, j, lo, hi, sum;
		for (i = 0; i < N_SAMP; i++)
			srt[i] = sh_samples[i];
		for (i = 1; i < N_SAMP; i++) begin
			key = srt[i];
			j = i;
			while (j > 0 && srt[j-1] > key) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = key;
		end
		if ((N_SAMP % 2) == 0) begin
			lo = N_SAMP / 2 - 2;
			hi = N_SAMP / 2 + 1;
		end else begin
			lo = N_SAMP / 2 - 1;
			hi = N_SAMP / 2 + 1;
		end
		sum = 0;
		for (i = lo; i <= hi; i++)
			sum += int'(srt[i]);
		return ANG_W'(sum / (hi - lo + 1));
	endfunction

	function automatic heading_result_t calc_heading_result(input vane_req_t r);
		heading_result_t res;
		logic [wvhc_pkg::ANGLE_W-1:0] diff;
		int deg, hd;
		res = '0;
		if (r.action == ACT_READ) begin
			// the offline check sees the run before this read
			if (sh_fault_run > FAULT_MAX)
				sh_online = 1'b0;
			if (!r.valid) begin
				if (sh_fault_run < RUN_SAT)
					sh_fault_run++;
			end else begin
				sh_fault_run = 0;
				diff = r.raw - (sh_cal_valid ? sh_cal_zero : sh_boot_zero);
				deg = (int'(diff) * 360) / 1024;
				hd = (deg + 180) % 360;
				res.heading = HDG_W'(hd);
				res.abs_heading = HDG_W'((hd + int'(r.compass)) % 360);
				res.hvalid = 1'b1;
			end
		end else begin
			if (sh_sample_cnt < N_SAMP)
				sh_samples[sh_sample_cnt] = r.raw;
			sh_sample_cnt++;
			if (sh_sample_cnt >= N_SAMP) begin
				sh_cal_zero = middle_mean();
				sh_cal_valid = 1'b1;
				sh_sample_cnt = 0;
				res.done = 1'b1;
			end
		end
		res.online = sh_online;
		res.zero = sh_cal_valid ? sh_cal_zero : sh_boot_zero;
		return res;
	endfunction

	// sender: take the next request once the current one is gone
	always @(posedge clk or negedge arst_n) begin : tx_side
		vane_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				heading_q.push_back(calc_heading_result(req_r));
			if (pend_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				nxt = pend_q.pop_front();
				req_r <= nxt;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: check results and drive stall, with one long hold-off
	always @(posedge clk or negedge arst_n) begin : rx_side
		heading_result_t got, want;
		int hold_cnt;
		int rx_count;
		bit hold_used;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cnt = 0;
			rx_count = 0;
			hold_used = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{heading, heading_valid, absolute_heading, sensor_online,
					zero_in_use, calibration_done};
				rx_count++;
				if (heading_q.size() == 0) begin
					note_mismatch("result with no request pending", rx_count, 0);
				end else begin
					want = heading_q.pop_front();
					if (got.heading !== want.heading)
						note_mismatch("heading", int'(got.heading), int'(want.heading));
					if (got.hvalid !== want.hvalid)
						note_mismatch("heading_valid", int'(got.hvalid), int'(want.hvalid));
					if (got.abs_heading !== want.abs_heading)
						note_mismatch("absolute_heading", int'(got.abs_heading),
							int'(want.abs_heading));
					if (got.online !== want.online)
						note_mismatch("sensor_online", int'(got.online), int'(want.online));
					if (got.zero !== want.zero)
						note_mismatch("zero_in_use", int'(got.zero), int'(want.zero));
					if (got.done !== want.done)
						note_mismatch("calibration_done", int'(got.done), int'(want.done));
				end
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (!hold_used && rx_count >= HOLD_AT) begin
				hold_cnt = HOLD_LEN;
				hold_used = 1'b1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG) begin
				$display("timeout: no request moved for %0d cycles", quiet);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		@(negedge clk);
		while (pend_q.size() != 0 || heading_q.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	task automatic write_boot_zero(input logic [wvhc_pkg::ANGLE_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_boot_zero = v;
		@(negedge clk);
	endtask

	task automatic push_req(input logic act, input logic [wvhc_pkg::ANGLE_W-1:0] raw,
			input logic vld, input logic [wvhc_pkg::DEG_W-1:0] compass);
		vane_req_t r;
		// keep the sensor online unless this stretch may drop it
		if (act == ACT_READ && !vld && !fault_ok && gen_run >= FAULT_MAX)
			vld = 1'b1;
		if (act == ACT_READ)
			gen_run = vld ? 0 : gen_run + 1;
		r = '{act, raw, vld, compass};
		pend_q.push_back(r);
	endtask

	task automatic gen_mix(input int n);
		int cnt, len, k, pick;
		logic [wvhc_pkg::ANGLE_W-1:0] center;
		cnt = 0;
		while (cnt < n) begin
			pick = $urandom_range(0, 9);
			if (pick <= 4) begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					push_req(ACT_READ, ANG_W'($urandom_range(0, 1023)), 1'b1,
						HDG_W'($urandom_range(0, 511)));
			end else if (pick <= 6) begin
				len = $urandom_range(1, fault_ok ? 14 : 6);
				for (k = 0; k < len; k++)
					push_req(ACT_READ, ANG_W'($urandom_range(0, 1023)), 1'b0,
						HDG_W'($urandom_range(0, 511)));
			end else if (pick <= 8) begin
				len = $urandom_range(1, N_SAMP);
				center = ANG_W'($urandom_range(0, 1023));
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 1) != 0)
						push_req(ACT_SAMPLE, ANG_W'(center + $urandom_range(0, 40) - 20),
							$urandom_range(0, 3) != 0, HDG_W'($urandom_range(0, 511)));
					else
						push_req(ACT_SAMPLE, ANG_W'($urandom_range(0, 1023)),
							1'($urandom_range(0, 1)), HDG_W'($urandom_range(0, 511)));
				end
			end else begin
				len = 1;
				push_req(1'($urandom_range(0, 1)), ANG_W'($urandom_range(0, 1023)),
					1'($urandom_range(0, 1)), HDG_W'($urandom_range(0, 511)));
			end
			cnt += len;
		end
	endtask

	initial begin : stimulus
		int k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 30;
		rx_idle_pct = 83;

		// boot zero at its top, then bottom, before any calibration
		write_boot_zero(10'd1023);
		push_req(ACT_READ, 10'd0, 1'b1, 9'd0);
		push_req(ACT_READ, 10'd1023, 1'b1, 9'd359);
		push_req(ACT_READ, 10'd512, 1'b0, 9'd511);
		push_req(ACT_READ, 10'd1022, 1'b1, 9'd511);
		write_boot_zero(10'd0);
		push_req(ACT_READ, 10'd0, 1'b1, 9'd0);
		push_req(ACT_READ, 10'd1023, 1'b1, 9'd359);
		push_req(ACT_READ, 10'd1023, 1'b0, 9'd511);
		push_req(ACT_READ, 10'd0, 1'b0, 9'd0);
		push_req(ACT_READ, 10'd511, 1'b1, 9'd360);
		write_boot_zero(ANG_W'($urandom_range(1, 1022)));
		// full calibration run with extremes and invalid samples
		for (k = 0; k < N_SAMP; k++) begin
			case (k)
				0:       push_req(ACT_SAMPLE, 10'd0, 1'b1, 9'd0);
				1:       push_req(ACT_SAMPLE, 10'd1023, 1'b0, 9'd511);
				2:       push_req(ACT_SAMPLE, 10'd1023, 1'b1, 9'd359);
				default: push_req(ACT_SAMPLE, ANG_W'($urandom_range(0, 1023)), k[0],
					HDG_W'($urandom_range(0, 511)));
			endcase
		end
		push_req(ACT_READ, ANG_W'($urandom_range(0, 1023)), 1'b1,
			HDG_W'($urandom_range(0, 511)));
		gen_mix(330);

		write_boot_zero(ANG_W'($urandom_range(0, 1023)));
		tx_idle_pct = 83;
		rx_idle_pct = 30;
		gen_mix(330);

		write_boot_zero(10'd1023);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		gen_mix(100);
		// drop the sensor offline and drive the fault run into saturation
		fault_ok = 1'b1;
		for (k = 0; k < RUN_SAT + 15; k++)
			push_req(ACT_READ, ANG_W'($urandom_range(0, 1023)), 1'b0,
				HDG_W'($urandom_range(0, 511)));
		gen_mix(60);

		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (heading_q.size() != 0)
			note_mismatch("results never returned", 0, heading_q.size());
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/wvhc_pkg.sv
sv/wvhc_ctrl.sv
sv/wvhc_dp.sv
sv/wind_vane_heading_calibrator_top.sv
tb/tb.sv
